// ===== src/pidc_pkg.sv =====
`default_nettype none

package pidc_pkg;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF    = 16;
  localparam int FILTER_RC_US_DEF = 7958;

  // Microseconds per second, the time base of the interval input
  localparam int US_PER_S = 1000000;

  // Quotient bits retired per clock by the shared divider
  localparam int DIV_BITS_PER_CLK = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LPF_EN    = 3'd4;

  // Request kinds
  localparam logic [1:0] KIND_STEP  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_MAG,
    ST_MUL_IHI,
    ST_MUL_ILO,
    ST_DIV_I,
    ST_WAIT_I,
    ST_INT_ADD,
    ST_INT_CLAMP,
    ST_MUL_RATE,
    ST_DIV_RATE,
    ST_WAIT_RATE,
    ST_RATE_SAT,
    ST_FILT_SUB,
    ST_MUL_FILT,
    ST_DIV_FILT,
    ST_WAIT_FILT,
    ST_FILT_ADD,
    ST_MUL_D,
    ST_D_CAP,
    ST_SUM,
    ST_CTL,
    ST_DONE
  } pidc_state_t;

endpackage

`default_nettype wire

// ===== src/pid_controller_clamped_lpf.sv =====
// PID controller with clamped integrator and optional derivative low-pass, Q(FRAC_BITS)
// fixed point. Each request is a control step, a state clear or an integrator load, and
// gives exactly one result (control, integral). Clear, load and unused kinds go from idle
// straight to the done state. A control step runs through one shared 33x33 multiplier and one
// shared divider under a sequencer; the divider retires two quotient bits per clock over
// a (79-FRAC_BITS)-bit dividend. A step needs two divides (integral increment, raw rate)
// plus one more with the filter enabled. in_ready is high only between requests; a finished
// result sits in the output register, so the next request is taken while the previous
// result waits for out_ready. Configuration must be written through cfg_* only while the
// block holds no request; the block itself does not enforce this. cfg_ready is always high.
`default_nettype none

module pid_controller_clamped_lpf #(
  parameter int FRAC_BITS    = pidc_pkg::FRAC_BITS_DEF,
  parameter int FILTER_RC_US = pidc_pkg::FILTER_RC_US_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_kind,
  input  wire logic signed [31:0]             in_error,
  input  wire logic [15:0]                    in_interval_us,
  input  wire logic signed [31:0]             in_load_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [31:0]                  out_control,
  output logic signed [31:0]                  out_integral,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int P_W      = 64 - FRAC_BITS;
  localparam int PD_W     = P_W + 1;
  localparam int SUM_W    = P_W + 2;
  localparam int MAG_W    = 63 - FRAC_BITS;
  localparam int MAG_HI_W = MAG_W - 32;
  localparam int ACC_W    = MAG_HI_W + 16;
  localparam int NUM_W    = 79 - FRAC_BITS;
  localparam int ISUM_W   = NUM_W + 2;
  localparam int US_W     = $clog2(pidc_pkg::US_PER_S + 1);
  localparam int RC_W     = $clog2(FILTER_RC_US + 65536);
  localparam int DEN_W    = (RC_W > US_W) ? RC_W : US_W;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  pidc_pkg::pidc_state_t state_r;
  pidc_pkg::pidc_state_t state_nxt;

  // Configuration
  logic [31:0] gain_p_r;
  logic [31:0] gain_i_r;
  logic [31:0] gain_d_r;
  logic [30:0] lim_r;
  logic        lpf_en_r;

  // Controller state
  logic signed [31:0] integ_r;
  logic signed [31:0] prev_err_r;
  logic signed [31:0] prev_rate_r;

  // Working registers
  logic signed [31:0]       err_r;
  logic [31:0]              abs_err_r;
  logic signed [32:0]       diff_r;
  logic [15:0]              dt_r;
  logic signed [P_W-1:0]    p_r;
  logic [31:0]              mag_lo_r;
  logic [ACC_W-1:0]         acc_r;
  logic signed [ISUM_W-1:0] isum_r;
  logic signed [31:0]       rate_r;
  logic signed [32:0]       delta_r;
  logic signed [P_W-1:0]    d_r;
  logic signed [PD_W-1:0]   sum_r;
  logic signed [31:0]       ctl_r;
  logic signed [PROD_W-1:0] prod_r;

  logic               out_valid_r;
  logic signed [31:0] out_control_r;
  logic signed [31:0] out_integral_r;

  // Shared units
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quo;

  logic [MAG_HI_W-1:0]      mag_hi;
  logic [31:0]              mag_lo;
  logic [PROD_W-1:0]        prod_abs;
  logic signed [ISUM_W-1:0] inc_s;
  logic signed [ISUM_W-1:0] integ_x;
  logic signed [ISUM_W-1:0] lim_pos;
  logic signed [ISUM_W-1:0] lim_neg;
  logic signed [32:0]       filt_q;
  logic signed [SUM_W-1:0]  tot;
  logic                     out_load;

  // Slice the integrator product magnitude into multiplier-sized halves
  assign mag_hi   = prod_r[FRAC_BITS+MAG_W-1:FRAC_BITS+32];
  assign mag_lo   = prod_r[FRAC_BITS+31:FRAC_BITS];
  assign prod_abs = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  assign inc_s   = $signed({2'b00, div_quo});
  assign integ_x = ISUM_W'(integ_r);
  assign lim_pos = ISUM_W'($signed({1'b0, lim_r}));
  assign lim_neg = -lim_pos;
  assign filt_q  = $signed({1'b0, div_quo[31:0]});
  assign tot     = SUM_W'(sum_r) + SUM_W'(integ_r);

  assign in_ready     = (state_r == pidc_pkg::ST_IDLE);
  assign out_load     = (state_r == pidc_pkg::ST_DONE) && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign out_control  = out_control_r;
  assign out_integral = out_integral_r;
  assign cfg_ready    = 1'b1;

  pidc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence the step and steer the shared multiplier and divider
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      pidc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == pidc_pkg::KIND_STEP) ? pidc_pkg::ST_MUL_P
                                                       : pidc_pkg::ST_DONE;
        end
      end
      pidc_pkg::ST_MUL_P: begin
        mul_a     = {err_r[31], err_r};
        mul_b     = {1'b0, gain_p_r};
        state_nxt = pidc_pkg::ST_MUL_MAG;
      end
      pidc_pkg::ST_MUL_MAG: begin
        mul_a     = {1'b0, abs_err_r};
        mul_b     = {1'b0, gain_i_r};
        state_nxt = pidc_pkg::ST_MUL_IHI;
      end
      pidc_pkg::ST_MUL_IHI: begin
        mul_a     = MUL_W'(mag_hi);
        mul_b     = MUL_W'(dt_r);
        state_nxt = pidc_pkg::ST_MUL_ILO;
      end
      pidc_pkg::ST_MUL_ILO: begin
        mul_a     = MUL_W'(mag_lo_r);
        mul_b     = MUL_W'(dt_r);
        state_nxt = pidc_pkg::ST_DIV_I;
      end
      pidc_pkg::ST_DIV_I: begin
        div_start = 1'b1;
        div_num   = (NUM_W'(acc_r) << 32) + NUM_W'(prod_r[47:0]);
        div_den   = DEN_W'(pidc_pkg::US_PER_S);
        state_nxt = pidc_pkg::ST_WAIT_I;
      end
      pidc_pkg::ST_WAIT_I: begin
        if (div_done) begin
          state_nxt = pidc_pkg::ST_INT_ADD;
        end
      end
      pidc_pkg::ST_INT_ADD: begin
        state_nxt = pidc_pkg::ST_INT_CLAMP;
      end
      pidc_pkg::ST_INT_CLAMP: begin
        state_nxt = pidc_pkg::ST_MUL_RATE;
      end
      pidc_pkg::ST_MUL_RATE: begin
        mul_a     = diff_r;
        mul_b     = MUL_W'(pidc_pkg::US_PER_S);
        state_nxt = pidc_pkg::ST_DIV_RATE;
      end
      pidc_pkg::ST_DIV_RATE: begin
        div_start = 1'b1;
        div_num   = NUM_W'(prod_abs);
        div_den   = DEN_W'(dt_r);
        state_nxt = pidc_pkg::ST_WAIT_RATE;
      end
      pidc_pkg::ST_WAIT_RATE: begin
        if (div_done) begin
          state_nxt = pidc_pkg::ST_RATE_SAT;
        end
      end
      pidc_pkg::ST_RATE_SAT: begin
        state_nxt = lpf_en_r ? pidc_pkg::ST_FILT_SUB : pidc_pkg::ST_MUL_D;
      end
      pidc_pkg::ST_FILT_SUB: begin
        state_nxt = pidc_pkg::ST_MUL_FILT;
      end
      pidc_pkg::ST_MUL_FILT: begin
        mul_a     = delta_r;
        mul_b     = MUL_W'(dt_r);
        state_nxt = pidc_pkg::ST_DIV_FILT;
      end
      pidc_pkg::ST_DIV_FILT: begin
        div_start = 1'b1;
        div_num   = NUM_W'(prod_abs);
        div_den   = DEN_W'(FILTER_RC_US) + DEN_W'(dt_r);
        state_nxt = pidc_pkg::ST_WAIT_FILT;
      end
      pidc_pkg::ST_WAIT_FILT: begin
        if (div_done) begin
          state_nxt = pidc_pkg::ST_FILT_ADD;
        end
      end
      pidc_pkg::ST_FILT_ADD: begin
        state_nxt = pidc_pkg::ST_MUL_D;
      end
      pidc_pkg::ST_MUL_D: begin
        mul_a     = {1'b0, gain_d_r};
        mul_b     = {rate_r[31], rate_r};
        state_nxt = pidc_pkg::ST_D_CAP;
      end
      pidc_pkg::ST_D_CAP: begin
        state_nxt = pidc_pkg::ST_SUM;
      end
      pidc_pkg::ST_SUM: begin
        state_nxt = pidc_pkg::ST_CTL;
      end
      pidc_pkg::ST_CTL: begin
        state_nxt = pidc_pkg::ST_DONE;
      end
      pidc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = pidc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pidc_pkg::ST_IDLE;
      end
    endcase
  end

  // Update configuration, controller state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      lim_r       <= '0;
      lpf_en_r    <= 1'b0;
      integ_r     <= '0;
      prev_err_r  <= '0;
      prev_rate_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pidc_pkg::CFG_GAIN_P:    gain_p_r <= cfg_data;
          pidc_pkg::CFG_GAIN_I:    gain_i_r <= cfg_data;
          pidc_pkg::CFG_GAIN_D:    gain_d_r <= cfg_data;
          pidc_pkg::CFG_INT_LIMIT: lim_r    <= cfg_data[30:0];
          pidc_pkg::CFG_LPF_EN:    lpf_en_r <= cfg_data[0];
          default: ;
        endcase
      end

      case (state_r)
        pidc_pkg::ST_IDLE: begin
          if (in_valid) begin
            case (in_kind)
              pidc_pkg::KIND_CLEAR: begin
                integ_r     <= '0;
                prev_err_r  <= '0;
                prev_rate_r <= '0;
              end
              pidc_pkg::KIND_LOAD: integ_r <= in_load_value;
              default: ;
            endcase
          end
        end
        pidc_pkg::ST_INT_CLAMP: begin
          if (isum_r > lim_pos) begin
            integ_r <= 32'(lim_pos);
          end else if (isum_r < lim_neg) begin
            integ_r <= 32'(lim_neg);
          end else begin
            integ_r <= 32'(isum_r);
          end
        end
        pidc_pkg::ST_MUL_D: begin
          prev_err_r  <= err_r;
          prev_rate_r <= rate_r;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    case (state_r)
      pidc_pkg::ST_IDLE: begin
        if (in_valid) begin
          err_r     <= in_error;
          abs_err_r <= in_error[31] ? 32'(-in_error) : 32'(in_error);
          diff_r    <= 33'(in_error) - 33'(prev_err_r);
          dt_r      <= (in_interval_us == '0) ? 16'd1 : in_interval_us;
          ctl_r     <= '0;
        end
      end
      pidc_pkg::ST_MUL_MAG: p_r <= P_W'(prod_r >>> FRAC_BITS);
      pidc_pkg::ST_MUL_IHI: mag_lo_r <= mag_lo;
      pidc_pkg::ST_MUL_ILO: acc_r <= prod_r[ACC_W-1:0];
      pidc_pkg::ST_INT_ADD: begin
        isum_r <= err_r[31] ? (integ_x - inc_s) : (integ_x + inc_s);
      end
      pidc_pkg::ST_RATE_SAT: begin
        if (!diff_r[32]) begin
          rate_r <= (div_quo > NUM_W'(32'h7fffffff)) ? SAT_MAX : $signed(div_quo[31:0]);
        end else begin
          rate_r <= (div_quo > NUM_W'(33'h080000000)) ? SAT_MIN : -$signed(div_quo[31:0]);
        end
      end
      pidc_pkg::ST_FILT_SUB: delta_r <= 33'(rate_r) - 33'(prev_rate_r);
      pidc_pkg::ST_FILT_ADD: begin
        rate_r <= 32'(delta_r[32] ? (33'(prev_rate_r) - filt_q)
                                  : (33'(prev_rate_r) + filt_q));
      end
      pidc_pkg::ST_D_CAP: d_r <= P_W'(prod_r >>> FRAC_BITS);
      pidc_pkg::ST_SUM: sum_r <= PD_W'(p_r) + PD_W'(d_r);
      pidc_pkg::ST_CTL: begin
        if (tot > SUM_W'(SAT_MAX)) begin
          ctl_r <= SAT_MAX;
        end else if (tot < SUM_W'(SAT_MIN)) begin
          ctl_r <= SAT_MIN;
        end else begin
          ctl_r <= 32'(tot);
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_control_r  <= ctl_r;
      out_integral_r <= integ_r;
    end
  end

`ifndef SYNTH
  // Integrator lands inside the clamp after every control step
  a_integ_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pidc_pkg::ST_INT_CLAMP) |=>
      (integ_r <= $signed({1'b0, lim_r}) && integ_r >= -$signed({1'b0, lim_r})))
    else $error("integrator outside clamp after control step");

  // Divider completes only while the sequencer waits for it
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == pidc_pkg::ST_WAIT_I || state_r == pidc_pkg::ST_WAIT_RATE ||
                  state_r == pidc_pkg::ST_WAIT_FILT))
    else $error("divider finished outside a wait state");

  // A loaded result is presented and the sequencer returns to idle
  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && state_r == pidc_pkg::ST_IDLE))
    else $error("result not posted after completion");
`endif

endmodule

`default_nettype wire

// ===== src/pidc_div.sv =====
`default_nettype none

module pidc_div #(
  parameter int NUM_W = 63,
  parameter int DEN_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int STEPS = pidc_pkg::DIV_BITS_PER_CLK;
  localparam int ITER  = (NUM_W + STEPS - 1) / STEPS;
  localparam int PAD_W = ITER * STEPS;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [PAD_W-1:0] quo_r;
  logic [PAD_W-1:0] quo_nxt;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W:0]   trial;

  // Retire STEPS restoring-division steps: shift in a dividend bit, try subtract
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int k = 0; k < STEPS; k++) begin
      trial   = {rem_nxt, quo_nxt[PAD_W-1]};
      quo_nxt = {quo_nxt[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial      = trial - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DEN_W-1:0];
    end
  end

  // Count iterations and flag the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(ITER);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // Load operands, then advance the quotient/remainder pair
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= PAD_W'(num);
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r[NUM_W-1:0];

endmodule

`default_nettype wire
